// File: design/wwmc_pkg.sv
// ----------------------------------------------------------------------------
// Whole-word match counter package
// Request and response payload types, register indexes and the byte
// classification helpers shared by the match cells and the top level.
// ----------------------------------------------------------------------------
package wwmc_pkg;

   localparam int unsigned CSR_DATA_W  = 64;
   localparam int unsigned CSR_INDEX_W = 3;
   localparam int unsigned RUN_COUNT_W = 24;
   localparam int unsigned ADDED_W     = 2;
   localparam int unsigned CSR_LEN_W   = 6;

   // Register indexes of the configuration port
   localparam logic [CSR_INDEX_W-1:0] CSR_PATTERN_0   = 3'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_PATTERN_1   = 3'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_PATTERN_2   = 3'd2;
   localparam logic [CSR_INDEX_W-1:0] CSR_PATTERN_3   = 3'd3;
   localparam logic [CSR_INDEX_W-1:0] CSR_PATTERN_LEN = 3'd4;
   localparam logic [CSR_INDEX_W-1:0] CSR_CASE_SENS   = 3'd5;
   localparam logic [CSR_INDEX_W-1:0] CSR_WHOLE_WORD  = 3'd6;

   // Number of pattern registers and bytes per register
   localparam int unsigned PATTERN_REGS  = 4;
   localparam int unsigned BYTES_PER_REG = 8;

   localparam logic [7:0] CHAR_UNDERSCORE = 8'h5F;
   localparam logic [7:0] CHAR_UPPER_A    = 8'h41;
   localparam logic [7:0] CHAR_UPPER_Z    = 8'h5A;
   localparam logic [7:0] CHAR_LOWER_A    = 8'h61;
   localparam logic [7:0] CHAR_LOWER_Z    = 8'h7A;
   localparam logic [7:0] CHAR_DIGIT_0    = 8'h30;
   localparam logic [7:0] CHAR_DIGIT_9    = 8'h39;
   localparam logic [7:0] CASE_OFFSET     = 8'h20;

   typedef struct packed {
      logic [7:0] text_byte;
      logic       end_of_text;
   } req_type;

   typedef struct packed {
      logic [ADDED_W-1:0]     matches_added;
      logic [RUN_COUNT_W-1:0] running_count;
      logic                   count_final;
   } rsp_type;

   typedef struct packed {
      logic case_sensitive;
      logic whole_word;
   } csr_flags_type;

   function automatic logic [7:0] fold_byte(input logic [7:0] c, input logic case_sensitive);
      logic [7:0] r;
      r = c;
      if (!case_sensitive && c >= CHAR_UPPER_A && c <= CHAR_UPPER_Z) begin
         r = c + CASE_OFFSET;
      end
      return r;
   endfunction

   function automatic logic is_word_byte(input logic [7:0] c);
      return (c >= CHAR_UPPER_A && c <= CHAR_UPPER_Z) ||
             (c >= CHAR_LOWER_A && c <= CHAR_LOWER_Z) ||
             (c >= CHAR_DIGIT_0 && c <= CHAR_DIGIT_9) ||
             (c == CHAR_UNDERSCORE);
   endfunction

endpackage

// File: design/whole_word_match_counter_unit.sv
// ----------------------------------------------------------------------------
// Whole-word match counter
// Streams text bytes and counts non-overlapping occurrences of a literal
// pattern, with optional ASCII case folding and word-boundary checks.
// ----------------------------------------------------------------------------
//
//  channel  direction  payload   handshake
//  -------  ---------  --------  ---------------------------------------
//  req      in         req_type  req_valid / req_stall (stall driven out)
//  rsp      out        rsp_type  rsp_valid / rsp_stall (stall driven in)
//  csr      in         64 bits   csr_write_enable, csr_index, no wait
//
//  One request per cycle while the output is not stalled; its response appears
//  in the output register in the cycle after acceptance. Each step shifts the
//  window in the cell row, runs a parallel compare and updates skip/pending.
//  Reset clears the search state, the count and the output valid flag and
//  loads the configuration reset values (pattern length one).
//  A stalled response holds the output register; req_stall rises only while
//  a response is held, so a request is taken whenever the output frees up.
//
module whole_word_match_counter_unit
   import wwmc_pkg::*;
#(
   parameter int PATTERN_MAX = 32,
   parameter int COUNT_BITS  = 24
)
(
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_stall,
   input  req_type                req_data,
   output logic                   rsp_valid,
   input  logic                   rsp_stall,
   output rsp_type                rsp_data,
   input  logic                   csr_write_enable,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [CSR_DATA_W-1:0]  csr_data
);

   localparam int WIN_DEPTH = PATTERN_MAX + 1;
   localparam int LEN_W     = $clog2(PATTERN_MAX + 1);
   localparam int SEEN_W    = $clog2(PATTERN_MAX + 2);
   localparam int EXT_W     = (COUNT_BITS > RUN_COUNT_W) ? COUNT_BITS : RUN_COUNT_W;

   // Configuration
   csr_flags_type            flags;
   logic [LEN_W-1:0]         pattern_length;
   logic [8*PATTERN_MAX-1:0] expect_flat;

   // Cell row
   logic [7:0]           cell_byte [WIN_DEPTH];
   logic [7:0]           cell_in   [WIN_DEPTH];
   logic [WIN_DEPTH-1:0] cell_eq;
   logic [WIN_DEPTH-1:0] cell_word;

   // Text state
   logic [SEEN_W-1:0]     seen_ff, seen_in;
   logic [LEN_W-1:0]      skip_ff, skip_in;
   logic                  pending_ff, pending_in;
   logic [COUNT_BITS-1:0] total_ff, total_in;

   // Output register
   logic    rsp_valid_ff, rsp_valid_in;
   rsp_type rsp_data_ff, rsp_data_in;

   logic              accept;
   logic              hit;
   logic              lead_ok;
   logic [ADDED_W-1:0] added;
   logic [COUNT_BITS:0] sum;
   logic [COUNT_BITS-1:0] total_sat;
   logic [EXT_W-1:0]  total_ext;

   wwmc_csr #(
      .PATTERN_MAX (PATTERN_MAX)
   ) u_csr (
      .clock            (clock),
      .reset            (reset),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_data         (csr_data),
      .flags            (flags),
      .pattern_length   (pattern_length),
      .expect_flat      (expect_flat)
   );

   // Hold a new request back only while a response waits
   assign req_stall = rsp_valid_ff & rsp_stall;
   assign accept    = req_valid & ~req_stall;

   // Build the window: the newest byte enters cell 0, each cell feeds the next
   genvar g;
   generate
      for (g = 0; g < WIN_DEPTH; g++) begin : g_cell
         logic [7:0] expect_byte;
         if (g == 0) begin : g_head
            assign cell_in[g] = req_data.text_byte;
         end else begin : g_link
            assign cell_in[g] = cell_byte[g-1];
         end
         if (g < PATTERN_MAX) begin : g_pat
            assign expect_byte = expect_flat[8*g +: 8];
         end else begin : g_nopat
            assign expect_byte = 8'h00;
         end
         wwmc_cell u_cell (
            .clock       (clock),
            .advance     (accept),
            .clear       (req_data.end_of_text),
            .shift_in    (cell_in[g]),
            .expect_byte (expect_byte),
            .flags       (flags),
            .byte_out    (cell_byte[g]),
            .eq_out      (cell_eq[g]),
            .word_out    (cell_word[g])
         );
      end
   endgenerate

   // Full match: every cell inside the pattern length agrees
   always_comb begin
      hit = 1'b1;
      for (int i = 0; i < WIN_DEPTH; i++) begin
         if (i < int'(pattern_length) && !cell_eq[i]) begin
            hit = 1'b0;
         end
      end
   end

   // Step: settle a pending candidate, then skip or look for a new candidate
   always_comb begin
      seen_in    = seen_ff;
      skip_in    = skip_ff;
      pending_in = 1'b0;
      added      = '0;
      lead_ok    = 1'b0;

      if (int'(seen_ff) < WIN_DEPTH) begin
         seen_in = seen_ff + SEEN_W'(1);
      end

      // Trailing byte decides a waiting candidate
      if (pending_ff && !is_word_byte(req_data.text_byte)) begin
         added = added + ADDED_W'(1);
      end

      if (skip_ff != '0) begin
         skip_in = skip_ff - LEN_W'(1);
      end else if (pattern_length != '0 &&
                   seen_in >= SEEN_W'(pattern_length) && hit) begin
         skip_in = pattern_length - LEN_W'(1);
         if (flags.whole_word) begin
            lead_ok = (seen_in <= SEEN_W'(pattern_length)) ||
                      !cell_word[pattern_length];
            if (lead_ok) begin
               if (req_data.end_of_text) begin
                  added = added + ADDED_W'(1);
               end else begin
                  pending_in = 1'b1;
               end
            end
         end else begin
            added = added + ADDED_W'(1);
         end
      end

      // Saturate the count
      sum       = {1'b0, total_ff} + (COUNT_BITS+1)'(added);
      total_sat = sum[COUNT_BITS] ? '1 : sum[COUNT_BITS-1:0];
      total_in  = total_sat;
      total_ext = EXT_W'(total_sat);

      rsp_data_in.matches_added = added;
      rsp_data_in.running_count = total_ext[RUN_COUNT_W-1:0];
      rsp_data_in.count_final   = req_data.end_of_text;

      // Drop all text state once the text ends
      if (req_data.end_of_text) begin
         seen_in    = '0;
         skip_in    = '0;
         pending_in = 1'b0;
         total_in   = '0;
      end
   end

   assign rsp_valid_in = accept | req_stall;

   always_ff @(posedge clock) begin
      if (reset) begin
         seen_ff      <= '0;
         skip_ff      <= '0;
         pending_ff   <= 1'b0;
         total_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
         if (accept) begin
            seen_ff    <= seen_in;
            skip_ff    <= skip_in;
            pending_ff <= pending_in;
            total_ff   <= total_in;
         end
      end
   end

   // Advance the response payload only with a new request
   always_ff @(posedge clock) begin
      if (accept) begin
         rsp_data_ff <= rsp_data_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule

// File: design/wwmc_cell.sv
// ----------------------------------------------------------------------------
// Match cell
// Holds one byte of the text window, passes it on to its neighbor on every
// request and compares the byte it is about to hold with its pattern byte.
// ----------------------------------------------------------------------------
module wwmc_cell
   import wwmc_pkg::*;
(
   input  logic          clock,
   input  logic          advance,
   input  logic          clear,
   input  logic [7:0]    shift_in,
   input  logic [7:0]    expect_byte,
   input  csr_flags_type flags,
   output logic [7:0]    byte_out,
   output logic          eq_out,
   output logic          word_out
);

   logic [7:0] byte_ff;
   logic [7:0] byte_in;

   // Load zero at text end, else take the neighbor's byte
   assign byte_in = clear ? 8'h00 : shift_in;

   always_ff @(posedge clock) begin
      if (advance) begin
         byte_ff <= byte_in;
      end
   end

   assign byte_out = byte_ff;
   assign eq_out   = fold_byte(shift_in, flags.case_sensitive) ==
                     fold_byte(expect_byte, flags.case_sensitive);
   assign word_out = is_word_byte(shift_in);

endmodule

// File: design/wwmc_csr.sv
// ----------------------------------------------------------------------------
// Configuration registers
// Holds pattern, length and mode bits and aligns the pattern so that each
// window cell sees the pattern byte it must match.
// ----------------------------------------------------------------------------
module wwmc_csr
   import wwmc_pkg::*;
#(
   parameter int PATTERN_MAX = 32
)
(
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           csr_write_enable,
   input  logic [CSR_INDEX_W-1:0]         csr_index,
   input  logic [CSR_DATA_W-1:0]          csr_data,
   output csr_flags_type                  flags,
   output logic [$clog2(PATTERN_MAX+1)-1:0] pattern_length,
   output logic [8*PATTERN_MAX-1:0]       expect_flat
);

   localparam int LEN_W = $clog2(PATTERN_MAX + 1);
   localparam int PAT_W = 8 * PATTERN_MAX;

   logic [PAT_W-1:0]     pattern_ff;
   logic [CSR_LEN_W-1:0] length_ff;
   csr_flags_type        flags_ff;

   logic [PAT_W-1:0] rev_flat;
   logic [LEN_W-1:0] shamt;

   always_ff @(posedge clock) begin
      if (reset) begin
         pattern_ff <= '0;
         length_ff  <= CSR_LEN_W'(1);
         flags_ff   <= '0;
      end else if (csr_write_enable) begin
         for (int p = 0; p < PATTERN_MAX; p++) begin
            if (p < PATTERN_REGS * BYTES_PER_REG &&
                csr_index == CSR_INDEX_W'(p / BYTES_PER_REG)) begin
               pattern_ff[8*p +: 8] <= csr_data[8*(p % BYTES_PER_REG) +: 8];
            end
         end
         unique case (csr_index)
            CSR_PATTERN_LEN: length_ff               <= csr_data[CSR_LEN_W-1:0];
            CSR_CASE_SENS:   flags_ff.case_sensitive <= csr_data[0];
            CSR_WHOLE_WORD:  flags_ff.whole_word     <= csr_data[0];
            default: ;
         endcase
      end
   end

   // Cap the length at PATTERN_MAX
   always_comb begin
      if (int'(length_ff) > PATTERN_MAX) begin
         pattern_length = LEN_W'(PATTERN_MAX);
      end else begin
         pattern_length = LEN_W'(length_ff);
      end
   end

   // Cell i needs pattern byte len-1-i: reverse the pattern, then shift down
   always_comb begin
      for (int i = 0; i < PATTERN_MAX; i++) begin
         rev_flat[8*i +: 8] = pattern_ff[8*(PATTERN_MAX-1-i) +: 8];
      end
   end

   assign shamt       = LEN_W'(PATTERN_MAX) - pattern_length;
   assign expect_flat = rev_flat >> {shamt, 3'b000};
   assign flags       = flags_ff;

endmodule

// File: sim/whole_word_match_counter_unit_tb.sv
// ----------------------------------------------------------------------------
// Whole-word match counter testbench
// Streams text bytes through the counter and compares every response with
// a cycle-free predictor kept in step with each accepted request and each
// register write. A short scripted run covers reset values, zero and
// oversized pattern lengths, case folding, word boundaries and a pending
// match settled across a mode change. Random phases follow: texts built
// from pattern copies, near misses, separators and noise, with random
// idling on both channels, a long receiver hold-off and a calm stretch.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module whole_word_match_counter_unit_tb;
   import wwmc_pkg::*;

   localparam int PATTERN_MAX = 32;
   localparam int WIN_DEPTH   = PATTERN_MAX + 1;
   localparam logic [RUN_COUNT_W-1:0] COUNT_MAX = '1;
   // Index with no register behind it; writes to it must change nothing
   localparam logic [CSR_INDEX_W-1:0] CSR_UNMAPPED = 3'd7;

   localparam int IDLE_PERCENT    = 29;
   localparam int HOLD_OFF_CYCLES = 80;
   localparam int SETTLE_CYCLES   = 3;
   localparam int WATCHDOG_LIMIT  = 2000;
   localparam int RANDOM_TARGET   = 500;

   typedef enum logic {ROW_TEXT, ROW_CSR} row_kind_type;

   // One step of the scripted run: either a text byte (optionally with a
   // response pinned by hand) or a register write
   typedef struct {
      row_kind_type           kind;
      req_type                req;
      bit                     pinned;
      rsp_type                want;
      logic [CSR_INDEX_W-1:0] index;
      logic [CSR_DATA_W-1:0]  value;
   } script_row_type;

   // DUT ports; the ones driven here are known from time zero
   logic                   clock = 1'b0;
   logic                   reset = 1'b1;
   logic                   req_valid = 1'b0;
   logic                   req_stall;
   req_type                req_data = '0;
   logic                   rsp_valid;
   logic                   rsp_stall = 1'b0;
   rsp_type                rsp_data;
   logic                   csr_write_enable = 1'b0;
   logic [CSR_INDEX_W-1:0] csr_index = '0;
   logic [CSR_DATA_W-1:0]  csr_data = '0;

   // Side band that travels with each request: a hand-typed response
   bit      req_pinned = 1'b0;
   rsp_type req_pinned_rsp = '0;

   // Predictor state: configuration copy and per-text search state
   logic [7:0]             pat_bytes [PATTERN_MAX];
   logic [CSR_LEN_W-1:0]   pat_len_reg;
   logic                   case_exact;
   logic                   word_mode;
   logic [7:0]             window_bytes [WIN_DEPTH];
   int                     seen_count;
   int                     skip_count;
   bit                     candidate_waiting;
   logic [RUN_COUNT_W-1:0] text_total;
   int                     step_added;

   rsp_type expected_counts [$];
   script_row_type script [$];
   logic [7:0] phase_pattern [PATTERN_MAX];

   int error_count = 0;
   int requests_sent = 0;
   int responses_checked = 0;
   int texts_closed = 0;
   int settings_loaded = 0;
   logic [RUN_COUNT_W-1:0] peak_count = '0;

   // Flow control shared between stimulus and receiver
   bit calm = 1'b0;
   bit hold_off_ask = 1'b0;
   bit hold_off_done = 1'b0;

   whole_word_match_counter_unit #(
      .PATTERN_MAX (PATTERN_MAX),
      .COUNT_BITS  (RUN_COUNT_W)
   ) dut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_data         (req_data),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_data         (rsp_data),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_data         (csr_data)
   );

   initial begin
      forever #5 clock = ~clock;
   end

   // ------------------------------------------------------------------------
   // Predictor
   // ------------------------------------------------------------------------

   // Map A-Z onto a-z unless exact compare is selected
   function automatic logic [7:0] lower_ascii(input logic [7:0] c);
      if (!case_exact && c >= CHAR_UPPER_A && c <= CHAR_UPPER_Z) begin
         return c ^ CASE_OFFSET;
      end
      return c;
   endfunction

   function automatic bit word_char(input logic [7:0] c);
      logic [7:0] low;
      low = c | CASE_OFFSET;
      if (low >= CHAR_LOWER_A && low <= CHAR_LOWER_Z) begin
         return 1'b1;
      end
      return (c >= CHAR_DIGIT_0 && c <= CHAR_DIGIT_9) || c == CHAR_UNDERSCORE;
   endfunction

   // Confirm one match: always reported, counted only below saturation
   function automatic void credit_match();
      step_added++;
      if (text_total != COUNT_MAX) begin
         text_total++;
      end
   endfunction

   function automatic void clear_text_state();
      foreach (window_bytes[i]) window_bytes[i] = '0;
      seen_count = 0;
      skip_count = 0;
      candidate_waiting = 1'b0;
      text_total = '0;
   endfunction

   function automatic void model_reset();
      foreach (pat_bytes[i]) pat_bytes[i] = '0;
      pat_len_reg = CSR_LEN_W'(1);
      case_exact = 1'b0;
      word_mode = 1'b0;
      clear_text_state();
   endfunction

   function automatic void apply_csr(input logic [CSR_INDEX_W-1:0] idx,
                                     input logic [CSR_DATA_W-1:0] val);
      int k;
      case (idx) inside
         CSR_PATTERN_0, CSR_PATTERN_1, CSR_PATTERN_2, CSR_PATTERN_3: begin
            for (k = 0; k < BYTES_PER_REG; k++) begin
               pat_bytes[idx * BYTES_PER_REG + k] = val[8*k +: 8];
            end
         end
         CSR_PATTERN_LEN: pat_len_reg = val[CSR_LEN_W-1:0];
         CSR_CASE_SENS:   case_exact = val[0];
         CSR_WHOLE_WORD:  word_mode = val[0];
         default: ;
      endcase
   endfunction

   // Advance the search by one text byte and return the response it causes
   function automatic rsp_type count_step(input req_type r);
      int n;
      int j;
      bit hit;
      bit lead_ok;
      rsp_type o;
      n = (pat_len_reg > PATTERN_MAX) ? PATTERN_MAX : int'(pat_len_reg);
      step_added = 0;
      for (j = WIN_DEPTH - 1; j > 0; j--) begin
         window_bytes[j] = window_bytes[j - 1];
      end
      window_bytes[0] = r.text_byte;
      if (seen_count < WIN_DEPTH) begin
         seen_count++;
      end
      // A waiting candidate is settled by this byte alone
      if (candidate_waiting) begin
         if (!word_char(r.text_byte)) begin
            credit_match();
         end
         candidate_waiting = 1'b0;
      end
      if (skip_count > 0) begin
         skip_count--;
      end else if (n > 0 && seen_count >= n) begin
         hit = 1'b1;
         for (j = 0; j < n; j++) begin
            if (lower_ascii(window_bytes[n - 1 - j]) != lower_ascii(pat_bytes[j])) begin
               hit = 1'b0;
            end
         end
         if (hit) begin
            skip_count = n - 1;
            if (word_mode) begin
               lead_ok = seen_count <= n || !word_char(window_bytes[n]);
               if (lead_ok && r.end_of_text) begin
                  credit_match();
               end else if (lead_ok) begin
                  candidate_waiting = 1'b1;
               end
            end else begin
               credit_match();
            end
         end
      end
      o.matches_added = ADDED_W'(step_added);
      o.running_count = text_total;
      o.count_final = r.end_of_text;
      if (r.end_of_text) begin
         clear_text_state();
      end
      return o;
   endfunction

   // ------------------------------------------------------------------------
   // Scoreboard: sample both channels and the register port at each edge
   // ------------------------------------------------------------------------

   task automatic log_mismatch(input string what, input longint got, input longint want);
      $display("MISMATCH %s: got %0d, expected %0d (response %0d, t=%0t)",
               what, got, want, responses_checked, $time);
      error_count++;
   endtask

   always @(posedge clock) begin : scoreboard
      rsp_type want;
      rsp_type got;
      if (reset) begin
         model_reset();
         expected_counts.delete();
      end else begin
         // Check the response first; it always belongs to an older request
         if (rsp_valid && !rsp_stall) begin
            got = rsp_data;
            if (expected_counts.size() == 0) begin
               log_mismatch("response with no request outstanding",
                            got.running_count, 0);
            end else begin
               want = expected_counts.pop_front();
               if (got.matches_added != want.matches_added) begin
                  log_mismatch("matches_added", got.matches_added, want.matches_added);
               end
               if (got.running_count != want.running_count) begin
                  log_mismatch("running_count", got.running_count, want.running_count);
               end
               if (got.count_final != want.count_final) begin
                  log_mismatch("count_final", got.count_final, want.count_final);
               end
            end
            responses_checked++;
            if (got.count_final) begin
               texts_closed++;
            end
            if (got.running_count > peak_count) begin
               peak_count = got.running_count;
            end
         end
         // Predict every accepted request; a pinned response overrides
         if (req_valid && !req_stall) begin
            want = count_step(req_data);
            if (req_pinned) begin
               want = req_pinned_rsp;
            end
            expected_counts.push_back(want);
         end
         // Register writes take effect from the next request on
         if (csr_write_enable) begin
            apply_csr(csr_index, csr_data);
         end
      end
   end

   // ------------------------------------------------------------------------
   // Watchdog: end the run if no handshake happens for too long
   // ------------------------------------------------------------------------
   initial begin : watchdog
      int quiet;
      quiet = 0;
      while (quiet < WATCHDOG_LIMIT) begin
         @(posedge clock);
         if (reset || csr_write_enable || (req_valid && !req_stall) ||
             (rsp_valid && !rsp_stall)) begin
            quiet = 0;
         end else begin
            quiet++;
         end
      end
      $display("TIMEOUT: no handshake for %0d cycles, %0d responses outstanding",
               WATCHDOG_LIMIT, expected_counts.size());
      $display("DONE: errors detected");
      $finish;
   end

   // ------------------------------------------------------------------------
   // Receiver: random stalls, none in the calm stretch, one long hold-off
   // ------------------------------------------------------------------------
   initial begin : receiver
      forever begin
         @(posedge clock);
         if (hold_off_ask && !hold_off_done) begin
            // Hold off long enough for the block to fill and stall its input
            rsp_stall <= 1'b1;
            repeat (HOLD_OFF_CYCLES) @(posedge clock);
            hold_off_done = 1'b1;
         end
         rsp_stall <= !calm && ($urandom_range(99) < IDLE_PERCENT);
      end
   end

   // ------------------------------------------------------------------------
   // Sender side
   // ------------------------------------------------------------------------

   // Offer one request, idling at random first, and hold it until taken
   task automatic send_text_byte(input logic [7:0] b, input logic eot,
                                 input bit pinned, input rsp_type want);
      req_type r;
      r.text_byte = b;
      r.end_of_text = eot;
      while (!calm && $urandom_range(99) < IDLE_PERCENT) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data <= r;
      req_pinned <= pinned;
      req_pinned_rsp <= want;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      requests_sent++;
   endtask

   // Stop offering and wait until every outstanding response has arrived
   task automatic drain_counts();
      req_valid <= 1'b0;
      @(posedge clock);
      while (expected_counts.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // Write one register; drop the enable only after the last of a burst
   task automatic write_reg(input logic [CSR_INDEX_W-1:0] idx,
                            input logic [CSR_DATA_W-1:0] val, input bit last);
      csr_write_enable <= 1'b1;
      csr_index <= idx;
      csr_data <= val;
      @(posedge clock);
      if (last) begin
         csr_write_enable <= 1'b0;
      end
   endtask

   // Load the phase pattern and mode bits into every register
   task automatic load_phase_config(input logic [CSR_LEN_W-1:0] len,
                                    input logic cs, input logic ww);
      logic [CSR_DATA_W-1:0] packed_bytes;
      int r;
      int k;
      for (r = 0; r < PATTERN_REGS; r++) begin
         for (k = 0; k < BYTES_PER_REG; k++) begin
            packed_bytes[8*k +: 8] = phase_pattern[r * BYTES_PER_REG + k];
         end
         write_reg(CSR_INDEX_W'(CSR_PATTERN_0 + r), packed_bytes, 1'b0);
      end
      write_reg(CSR_PATTERN_LEN, CSR_DATA_W'(len), 1'b0);
      write_reg(CSR_CASE_SENS, CSR_DATA_W'(cs) | ($urandom() & ~64'h1), 1'b0);
      write_reg(CSR_WHOLE_WORD, CSR_DATA_W'(ww), 1'b1);
      settings_loaded++;
   endtask

   // Pattern alphabet: few letters so copies overlap, plus boundaries and noise
   function automatic logic [7:0] pick_pattern_byte();
      case ($urandom_range(7))
         0, 1:    return 8'(CHAR_LOWER_A + $urandom_range(2));
         2:       return 8'(CHAR_UPPER_A + $urandom_range(2));
         3:       return CHAR_UNDERSCORE;
         4:       return 8'(CHAR_DIGIT_0 + $urandom_range(9));
         5:       return 8'h2E;
         default: return 8'($urandom_range(255));
      endcase
   endfunction

   // Build one text from pattern copies, broken copies, word bytes,
   // separators and noise, then stream it; close it with end of text or not
   task automatic send_random_text(input int n, input bit close, input int min_len);
      logic [7:0] text_q [$];
      logic [7:0] c;
      int target;
      int copy_len;
      int k;
      target = (n > 6) ? $urandom_range(n + 40, n) : $urandom_range(20, 1);
      if (target < min_len) begin
         target = min_len;
      end
      while (text_q.size() < target) begin
         case ($urandom_range(9))
            0, 1, 2, 3: begin
               if (n > 0) begin
                  copy_len = (n > 1 && $urandom_range(3) == 0) ? $urandom_range(n - 1, 1) : n;
                  for (k = 0; k < copy_len; k++) begin
                     c = phase_pattern[k];
                     // Flip case now and then: a hit when folding, a miss when exact
                     if (word_char(c) && c > CHAR_DIGIT_9 && c != CHAR_UNDERSCORE &&
                         $urandom_range(3) == 0) begin
                        c = c ^ CASE_OFFSET;
                     end
                     text_q.push_back(c);
                  end
               end else begin
                  text_q.push_back(8'(CHAR_LOWER_A + $urandom_range(2)));
               end
            end
            4, 5: begin
               case ($urandom_range(2))
                  0:       text_q.push_back(8'h20);
                  1:       text_q.push_back(8'h2E);
                  default: text_q.push_back(8'($urandom_range(8'h2F)));
               endcase
            end
            6: text_q.push_back(phase_pattern[$urandom_range(PATTERN_MAX - 1)]);
            7: begin
               case ($urandom_range(3))
                  0:       text_q.push_back(8'(CHAR_LOWER_A + $urandom_range(25)));
                  1:       text_q.push_back(8'(CHAR_UPPER_A + $urandom_range(25)));
                  2:       text_q.push_back(8'(CHAR_DIGIT_0 + $urandom_range(9)));
                  default: text_q.push_back(CHAR_UNDERSCORE);
               endcase
            end
            default: text_q.push_back(8'($urandom_range(255)));
         endcase
      end
      for (k = 0; k < text_q.size(); k++) begin
         send_text_byte(text_q[k], close && k == text_q.size() - 1, 1'b0, '0);
      end
   endtask

   // ------------------------------------------------------------------------
   // Script helpers
   // ------------------------------------------------------------------------
   function automatic void add_text(input logic [7:0] b, input logic eot);
      script_row_type row;
      row = '{kind: ROW_TEXT, req: '0, pinned: 1'b0, want: '0, index: '0, value: '0};
      row.req.text_byte = b;
      row.req.end_of_text = eot;
      script.push_back(row);
   endfunction

   function automatic void add_pinned(input logic [7:0] b, input logic eot,
                                      input int added, input int count, input logic fin);
      add_text(b, eot);
      script[$].pinned = 1'b1;
      script[$].want.matches_added = ADDED_W'(added);
      script[$].want.running_count = RUN_COUNT_W'(count);
      script[$].want.count_final = fin;
   endfunction

   function automatic void add_reg(input logic [CSR_INDEX_W-1:0] idx,
                                   input logic [CSR_DATA_W-1:0] val);
      script_row_type row;
      row = '{kind: ROW_CSR, req: '0, pinned: 1'b0, want: '0, index: idx, value: val};
      script.push_back(row);
   endfunction

   // ------------------------------------------------------------------------
   // Main sequence
   // ------------------------------------------------------------------------
   initial begin : stimulus
      int i;
      int phase;
      int texts;
      int t;
      int n;
      int sel;
      int directed_count;
      int random_sent;
      logic [CSR_LEN_W-1:0] len;

      repeat (10) @(posedge clock);
      reset <= 1'b0;

      // Reset values: one-byte pattern of NUL, folding on, no boundary test
      add_pinned(8'h00, 1'b0, 1, 1, 1'b1 & 1'b0);
      add_pinned(8'hFF, 1'b1, 0, 1, 1'b1);
      add_pinned("A", 1'b1, 0, 0, 1'b1);

      // Pattern "ab" in whole-word mode; unused bytes carry junk
      add_reg(CSR_PATTERN_0, 64'hFFFF_FFFF_FFFF_6261);
      add_reg(CSR_PATTERN_1, '1);
      add_reg(CSR_PATTERN_2, '0);
      add_reg(CSR_PATTERN_3, 64'h5555_AAAA_0F0F_F0F0);
      add_reg(CSR_PATTERN_LEN, 64'd2);
      add_reg(CSR_WHOLE_WORD, 64'd1);
      // Folded hit at text start settled by a space, then a hit that a word
      // byte rejects, then a hit settled by the end of the text
      add_text("A", 1'b0);
      add_text("B", 1'b0);
      add_text(" ", 1'b0);
      add_text("a", 1'b0);
      add_text("b", 1'b0);
      add_text("x", 1'b0);
      add_text(" ", 1'b0);
      add_text("a", 1'b0);
      add_text("b", 1'b1);

      // Exact compare misses upper case
      add_reg(CSR_CASE_SENS, 64'd1);
      add_text("A", 1'b0);
      add_text("B", 1'b1);

      // Leave a candidate waiting, drop whole-word mode, settle it anyway
      add_text("a", 1'b0);
      add_text("b", 1'b0);
      add_reg(CSR_WHOLE_WORD, 64'd0);
      add_text("!", 1'b1);

      // Write to an unmapped index, then zero length: nothing matches
      add_reg(CSR_UNMAPPED, '1);
      add_reg(CSR_PATTERN_LEN, 64'd0);
      add_pinned("a", 1'b0, 0, 0, 1'b0);
      add_pinned("b", 1'b1, 0, 0, 1'b1);

      // Non-word one-byte pattern: settle a waiting match and confirm a new
      // one on the same closing byte
      add_reg(CSR_PATTERN_0, 64'h2E);
      add_reg(CSR_PATTERN_LEN, 64'd1);
      add_reg(CSR_WHOLE_WORD, 64'd1);
      add_text(".", 1'b0);
      add_text(".", 1'b1);

      // Oversized length clamps to the full pattern; one byte cannot match
      add_reg(CSR_PATTERN_0, '1);
      add_reg(CSR_PATTERN_1, '1);
      add_reg(CSR_PATTERN_2, '1);
      add_reg(CSR_PATTERN_3, '1);
      add_reg(CSR_PATTERN_LEN, 64'h3F);
      add_pinned(8'hFF, 1'b1, 0, 0, 1'b1);

      // Walk the script; drain before the first write of each burst
      for (i = 0; i < script.size(); i++) begin
         if (script[i].kind == ROW_CSR) begin
            if (i == 0 || script[i - 1].kind != ROW_CSR) begin
               drain_counts();
            end
            write_reg(script[i].index, script[i].value,
                      i + 1 == script.size() || script[i + 1].kind != ROW_CSR);
         end else begin
            send_text_byte(script[i].req.text_byte, script[i].req.end_of_text,
                           script[i].pinned, script[i].want);
         end
      end
      directed_count = requests_sent;

      // Random phases: each drains, loads a new setting and streams texts.
      // Texts left open carry across the next setting change.
      phase = 0;
      random_sent = 0;
      while (random_sent < RANDOM_TARGET) begin
         case (phase)
            0: len = 6'd32;
            1: len = CSR_LEN_W'($urandom_range(63, 33));
            2: len = 6'd0;
            default: begin
               sel = $urandom_range(9);
               if (sel == 0) begin
                  len = 6'd0;
               end else if (sel == 1) begin
                  len = 6'd32;
               end else if (sel == 2) begin
                  len = CSR_LEN_W'($urandom_range(63, 33));
               end else begin
                  len = CSR_LEN_W'($urandom_range(6, 1));
               end
            end
         endcase
         foreach (phase_pattern[k]) phase_pattern[k] = pick_pattern_byte();
         n = (len > PATTERN_MAX) ? PATTERN_MAX : int'(len);

         drain_counts();
         load_phase_config(len, 1'($urandom_range(1)), 1'($urandom_range(1)));

         texts = $urandom_range(5, 2);
         for (t = 0; t < texts && random_sent < RANDOM_TARGET; t++) begin
            calm = random_sent >= 200 && random_sent < 320;
            if (!hold_off_ask && random_sent >= 100) begin
               // Keep offering through the whole hold-off
               hold_off_ask = 1'b1;
               send_random_text(n, 1'b1, 2 * HOLD_OFF_CYCLES);
            end else begin
               send_random_text(n, $urandom_range(4) != 0, 0);
            end
            random_sent = requests_sent - directed_count;
         end
         phase++;
      end
      calm = 1'b0;

      drain_counts();

      $display("Covered %0d requests (%0d scripted), %0d responses, %0d texts closed",
               requests_sent, directed_count, responses_checked, texts_closed);
      $display("  over %0d random pattern settings; peak running count %0d",
               settings_loaded, peak_count);
      if (error_count == 0) begin
         $display("DONE: 0 errors");
      end else begin
         $display("DONE: errors detected");
      end
      $finish;
   end

endmodule

// File: filelist.f
design/wwmc_pkg.sv
design/wwmc_cell.sv
design/wwmc_csr.sv
design/whole_word_match_counter_unit.sv
sim/whole_word_match_counter_unit_tb.sv
